### sv/emts_pkg.sv
package emts_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);

  // Configuration registers
  localparam int SIZE_W    = 12;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

  // Result fields
  localparam int CNT_W     = 23;
  localparam int Q_W       = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

  // Stream payload layout
  localparam int IN_W     = 8;
  localparam int OUT_W    = 104;
  localparam int TP_LSB   = 0;
  localparam int FP_LSB   = TP_LSB + CNT_W;
  localparam int FN_LSB   = FP_LSB + CNT_W;
  localparam int PREC_LSB = FN_LSB + CNT_W;
  localparam int REC_LSB  = PREC_LSB + Q_W;
  localparam int PAD_W    = OUT_W - (REC_LSB + Q_W);

  // Column queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // One column of the 3x3 window: col[1:0] top row, col[3:2] middle row,
  // col[5:4] bottom row; in each pair bit 0 is detected, bit 1 is truth.
  typedef struct packed {
    logic       frame_end;
    logic       last;
    logic       first;
    logic       judge;
    logic [5:0] col;
  } col_beat_t;

  typedef struct packed {
    logic tp;
    logic fp;
    logic fn;
  } verdict_t;

  // Classify the middle pixel of a 3x3 window given as three columns
  function automatic verdict_t judge_center(input logic [5:0] l, input logic [5:0] m,
                                            input logic [5:0] r);
    logic     near_d;
    logic     near_t;
    logic     d;
    logic     t;
    verdict_t v;
    near_d = l[0] | l[2] | l[4] | m[0] | m[2] | m[4] | r[0] | r[2] | r[4];
    near_t = l[1] | l[3] | l[5] | m[1] | m[3] | m[5] | r[1] | r[3] | r[5];
    d = m[2];
    t = m[3];
    v = '0;
    if (d && t) begin
      v.tp = 1'b1;
    end else if (d) begin
      if (near_t) v.tp = 1'b1;
      else        v.fp = 1'b1;
    end else if (t) begin
      if (near_d) v.tp = 1'b1;
      else        v.fn = 1'b1;
    end
    return v;
  endfunction

endpackage

### sv/emts_front.sv
module emts_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [emts_pkg::IN_W-1:0]       in_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [emts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emts_pkg::SIZE_W-1:0]     cfg_data,
  output logic                            cfg_restart,
  output logic                            push_valid,
  input  logic                            push_ready,
  output emts_pkg::col_beat_t             push_beat
);
  import emts_pkg::*;

  typedef enum logic [1:0] {
    ST_PIXEL = 2'b01,
    ST_FLUSH = 2'b10
  } front_state_t;

  typedef struct packed {
    logic [1:0]     pix;
    logic [X_W-1:0] x;
    logic           wr;
    logic           judge;
    logic           top_ok;
    logic           first;
    logic           last;
    logic           frame_end;
  } stage_t;

  front_state_t state_r, state_nxt;
  logic [SIZE_W-1:0] width_r, height_r;
  logic [X_W-1:0] x_last, x_r, x_nxt;
  logic [Y_W-1:0] y_last, y_r, y_nxt;
  stage_t s1_r, s1_nxt;
  logic s1_valid_r;
  logic s1_free, in_fire, flush_go, load, push_fire, wr_en;

  // Line store: bits [1:0] previous row, bits [3:2] the row above it
  logic [3:0] line_mem [MAX_WIDTH];
  logic [3:0] rd_r, fwd_data_r, rd_eff, wr_data;
  logic fwd_r;

  // Clamp the size registers to last column and last row indexes
  always_comb begin
    if (width_r == '0) x_last = '0;
    else if (int'(width_r) > MAX_WIDTH) x_last = X_W'(MAX_WIDTH - 1);
    else x_last = X_W'(width_r - 1'b1);
    if (height_r == '0) y_last = '0;
    else if (int'(height_r) > MAX_HEIGHT) y_last = Y_W'(MAX_HEIGHT - 1);
    else y_last = Y_W'(height_r - 1'b1);
  end

  // Handshakes
  assign cfg_ready   = 1'b1;
  assign cfg_restart = cfg_valid && (cfg_index == CFG_FRAME_WIDTH ||
                                     cfg_index == CFG_FRAME_HEIGHT);
  assign s1_free     = !s1_valid_r || push_ready;
  assign in_tready   = (state_r == ST_PIXEL) && s1_free;
  assign in_fire     = in_tvalid && in_tready;
  assign flush_go    = (state_r == ST_FLUSH) && s1_free;
  assign load        = in_fire || flush_go;
  assign push_valid  = s1_valid_r;
  assign push_fire   = s1_valid_r && push_ready;
  assign wr_en       = push_fire && s1_r.wr;

  // Build the next stage entry and advance the raster position
  always_comb begin
    x_nxt     = x_r;
    y_nxt     = y_r;
    state_nxt = state_r;
    s1_nxt    = '0;
    unique case (state_r)
      ST_PIXEL: begin
        s1_nxt.pix    = in_tdata[1:0];
        s1_nxt.x      = x_r;
        s1_nxt.wr     = 1'b1;
        s1_nxt.judge  = (y_r != '0);
        s1_nxt.top_ok = (y_r > Y_W'(1));
        s1_nxt.first  = (x_r == '0);
        s1_nxt.last   = (x_r == x_last);
        if (in_fire) begin
          if (x_r == x_last) begin
            x_nxt = '0;
            if (y_r == y_last) begin
              y_nxt     = '0;
              state_nxt = ST_FLUSH;
            end else begin
              y_nxt = y_r + 1'b1;
            end
          end else begin
            x_nxt = x_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        // Reread the last row with an empty row below it
        s1_nxt.x         = x_r;
        s1_nxt.judge     = 1'b1;
        s1_nxt.top_ok    = (y_last != '0);
        s1_nxt.first     = (x_r == '0);
        s1_nxt.last      = (x_r == x_last);
        s1_nxt.frame_end = (x_r == x_last);
        if (flush_go) begin
          if (x_r == x_last) begin
            x_nxt     = '0;
            state_nxt = ST_PIXEL;
          end else begin
            x_nxt = x_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_PIXEL;
      end
    endcase
    if (cfg_restart) begin
      x_nxt     = '0;
      y_nxt     = '0;
      state_nxt = ST_PIXEL;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_PIXEL;
      x_r        <= '0;
      y_r        <= '0;
      s1_valid_r <= 1'b0;
      width_r    <= RESET_WIDTH;
      height_r   <= RESET_HEIGHT;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      if (load) s1_valid_r <= 1'b1;
      else if (push_fire) s1_valid_r <= 1'b0;
      if (cfg_valid && cfg_index == CFG_FRAME_WIDTH) width_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_FRAME_HEIGHT) height_r <= cfg_data;
    end
  end

  // Hold the stage payload
  always_ff @(posedge clk) begin
    if (load) s1_r <= s1_nxt;
  end

  // Line store: read at the new position, write back the stage entry
  assign rd_eff  = fwd_r ? fwd_data_r : rd_r;
  assign wr_data = {rd_eff[1:0], s1_r.pix};

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[s1_r.x] <= wr_data;
    if (load) begin
      rd_r       <= line_mem[x_r];
      fwd_r      <= wr_en && (s1_r.x == x_r);
      fwd_data_r <= wr_data;
    end
  end

  // Column out to the queue, rows outside the frame forced clear
  always_comb begin
    push_beat           = '0;
    push_beat.col[1:0]  = s1_r.top_ok ? rd_eff[3:2] : 2'b00;
    push_beat.col[3:2]  = s1_r.judge ? rd_eff[1:0] : 2'b00;
    push_beat.col[5:4]  = s1_r.pix;
    push_beat.judge     = s1_r.judge;
    push_beat.first     = s1_r.first;
    push_beat.last      = s1_r.last;
    push_beat.frame_end = s1_r.frame_end;
  end

endmodule

### sv/emts_fifo.sv
module emts_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  emts_pkg::col_beat_t wr_beat,
  output logic                rd_valid,
  input  logic                rd_ready,
  output emts_pkg::col_beat_t rd_beat
);
  import emts_pkg::*;

  col_beat_t entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic wr_fire, rd_fire;

  assign wr_ready = (cnt_r != (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_beat  = entry_r[rp_r];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= wp_r + 1'b1;
      if (rd_fire) rp_r <= rp_r + 1'b1;
      if (wr_fire && !rd_fire) cnt_r <= cnt_r + 1'b1;
      else if (rd_fire && !wr_fire) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (wr_fire) entry_r[wp_r] <= wr_beat;
  end

endmodule

### sv/emts_div.sv
module emts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [emts_pkg::CNT_W-1:0] num,
  input  logic [emts_pkg::CNT_W:0]   den,
  output logic                      busy,
  output logic [emts_pkg::Q_W-1:0]   quot
);
  import emts_pkg::*;

  localparam int STEP_W = $clog2(Q_W + 1);

  logic [CNT_W+1:0] rem_r, rem_keep, rem_nxt, diff;
  logic [CNT_W:0]   den_r;
  logic [Q_W-1:0]   q_r;
  logic [STEP_W-1:0] step_r;
  logic busy_r, zero_r, take;

  // One restoring step: compare, subtract, shift
  assign diff     = rem_r - {1'b0, den_r};
  assign take     = (rem_r >= {1'b0, den_r});
  assign rem_keep = take ? diff : rem_r;
  assign rem_nxt  = {rem_keep[CNT_W:0], 1'b0};

  assign busy = busy_r;
  assign quot = zero_r ? '0 : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && step_r == STEP_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {2'b00, num};
      den_r  <= den;
      q_r    <= '0;
      step_r <= STEP_W'(Q_W);
      zero_r <= (num == '0);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      q_r    <= {q_r[Q_W-2:0], take};
      step_r <= step_r - 1'b1;
    end
  end

endmodule

### sv/emts_back.sv
module emts_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        col_valid,
  output logic                        col_ready,
  input  emts_pkg::col_beat_t         col_beat,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [emts_pkg::OUT_W-1:0]  out_tdata
);
  import emts_pkg::*;

  logic [5:0] prev1_r, prev2_r, left_b;
  logic [CNT_W-1:0] tp_r, fp_r, fn_r, tp_nxt, fp_nxt, fn_nxt;
  logic [CNT_W-1:0] snap_tp_r, snap_fp_r, snap_fn_r;
  logic [CNT_W:0]   prec_den, rec_den;
  logic [Q_W-1:0]   prec_q, rec_q;
  logic [1:0] tp_inc, fp_inc, fn_inc;
  verdict_t va, vb;
  logic en_a, en_b, pop, div_start, move, res_pend_r, prec_busy, rec_busy;
  logic out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W+1)'(inc);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Take a frame end only once the previous result has left the dividers
  assign col_ready = !col_beat.frame_end || !res_pend_r;
  assign pop       = col_valid && col_ready;
  assign div_start = pop && col_beat.frame_end;

  // Judge the center one column back, and at a row end the new column too
  assign left_b = col_beat.first ? 6'b000000 : prev1_r;
  assign va     = judge_center(prev2_r, prev1_r, col_beat.col);
  assign vb     = judge_center(left_b, col_beat.col, 6'b000000);
  assign en_a   = col_beat.judge && !col_beat.first;
  assign en_b   = col_beat.judge && col_beat.last;

  assign tp_inc = {1'b0, va.tp && en_a} + {1'b0, vb.tp && en_b};
  assign fp_inc = {1'b0, va.fp && en_a} + {1'b0, vb.fp && en_b};
  assign fn_inc = {1'b0, va.fn && en_a} + {1'b0, vb.fn && en_b};
  assign tp_nxt = sat_add(tp_r, tp_inc);
  assign fp_nxt = sat_add(fp_r, fp_inc);
  assign fn_nxt = sat_add(fn_r, fn_inc);

  assign prec_den = {1'b0, tp_nxt} + {1'b0, fp_nxt};
  assign rec_den  = {1'b0, tp_nxt} + {1'b0, fn_nxt};

  // Shift the window
  always_ff @(posedge clk) begin
    if (pop) begin
      prev2_r <= col_beat.first ? 6'b000000 : prev1_r;
      prev1_r <= col_beat.col;
    end
  end

  // Counts, cleared at frame end and on a size change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r <= '0;
      fp_r <= '0;
      fn_r <= '0;
    end else if (clear || div_start) begin
      tp_r <= '0;
      fp_r <= '0;
      fn_r <= '0;
    end else if (pop) begin
      tp_r <= tp_nxt;
      fp_r <= fp_nxt;
      fn_r <= fn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      snap_tp_r <= tp_nxt;
      snap_fp_r <= fp_nxt;
      snap_fn_r <= fn_nxt;
    end
  end

  emts_div u_prec (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tp_nxt),
    .den   (prec_den),
    .busy  (prec_busy),
    .quot  (prec_q)
  );

  emts_div u_rec (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (tp_nxt),
    .den   (rec_den),
    .busy  (rec_busy),
    .quot  (rec_q)
  );

  // Move a finished result into the output register
  assign move = res_pend_r && !prec_busy && !rec_busy && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (div_start) res_pend_r <= 1'b1;
      else if (move) res_pend_r <= 1'b0;
      if (move) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= {{PAD_W{1'b0}}, rec_q, prec_q, snap_fn_r, snap_fp_r, snap_tp_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### sv/edge_map_tolerance_scorer.sv
// Edge map tolerance scorer. Feed one pixel pair per beat in raster order
// (in_tdata bit 0 detected edge, bit 1 ground-truth edge); a pixel set in
// both maps, or set in one map with a set pixel of the other map in its
// 3x3 neighborhood clipped at the image borders, is a true positive, other
// set pixels are false positives or false negatives. Pixels are taken at
// one per clock while the column queue has room. After the last pixel of
// a frame the front end rereads the two-row line store to judge the bottom
// row, holding in_tready low meanwhile; the result beat then comes from
// the 17-step serial dividers for precision and recall, and a frame end
// waits in the column queue until the previous frame's result has moved
// from the dividers into the output register. Writing frame_width or
// frame_height restarts the frame and clears the counts; write them only
// while idle. The line store needs no clearing pass after reset.
module edge_map_tolerance_scorer (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [0] detected_edge, [1] truth_edge, [7:2] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [emts_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: [22:0] true_positives, [45:23] false_positives,
  // [68:46] false_negatives, [85:69] precision, [102:86] recall, [103] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [emts_pkg::OUT_W-1:0]      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [emts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emts_pkg::SIZE_W-1:0]     cfg_data
);
  import emts_pkg::*;

  logic      cfg_restart;
  logic      push_valid, push_ready, col_valid, col_ready;
  col_beat_t push_beat, col_beat;

  emts_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cfg_restart (cfg_restart),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_beat   (push_beat)
  );

  emts_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_beat  (push_beat),
    .rd_valid (col_valid),
    .rd_ready (col_ready),
    .rd_beat  (col_beat)
  );

  emts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_restart),
    .col_valid  (col_valid),
    .col_ready  (col_ready),
    .col_beat   (col_beat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### sv/emts_checker.sv
module emts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [emts_pkg::OUT_W-1:0] out_tdata
);
  import emts_pkg::*;

  logic [CNT_W-1:0] tp, fp, fn;
  logic [Q_W-1:0]   prec, rec;

  assign tp   = out_tdata[TP_LSB +: CNT_W];
  assign fp   = out_tdata[FP_LSB +: CNT_W];
  assign fn   = out_tdata[FN_LSB +: CNT_W];
  assign prec = out_tdata[PREC_LSB +: Q_W];
  assign rec  = out_tdata[REC_LSB +: Q_W];

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // No true positives gives zero fractions
  a_zero_tp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tp == '0 |-> prec == '0 && rec == '0)
    else $error("fractions not zero without true positives");

  // With true positives present, precision is one exactly when there are no false positives
  a_prec_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tp != '0 |-> ((fp == '0) == (prec == Q_ONE)))
    else $error("precision disagrees with false positive count");

  // With true positives present, recall is one exactly when there are no false negatives
  a_rec_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && tp != '0 |-> ((fn == '0) == (rec == Q_ONE)))
    else $error("recall disagrees with false negative count");

endmodule

bind edge_map_tolerance_scorer emts_checker u_checker (.*);
